[rtl/core/ekx_pkg.sv]
// ----------------------------------------------------------------------------
// ekx_pkg
// shared constants for the extrema keyframe extractor
// ----------------------------------------------------------------------------
package ekx_pkg;

    localparam int SCALE_BITS    = 16;
    localparam int RATE_BITS     = 18;
    localparam int DEN_BITS      = RATE_BITS + 1;
    localparam int POS_BITS      = 24;
    localparam int CFG_ADDR_BITS = 1;
    localparam int CFG_DATA_BITS = RATE_BITS;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [CFG_ADDR_BITS-1:0] REG_TIME_SCALE  = 1'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SAMPLE_RATE = 1'd1;

    localparam logic [SCALE_BITS-1:0] TIME_SCALE_RESET  = 16'd1000;
    localparam logic [RATE_BITS-1:0]  SAMPLE_RATE_RESET = 18'd8000;

endpackage

[rtl/core/ekx_queue.sv]
// ----------------------------------------------------------------------------
// ekx_queue
// short fifo of candidate operations between front and back
// ----------------------------------------------------------------------------
module ekx_queue #(
    parameter int WIDTH = 41
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = $clog2(ekx_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(ekx_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [ekx_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(ekx_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/core/ekx_front.sv]
// ----------------------------------------------------------------------------
// ekx_front
// sample window, index tracking and candidate classification
// ----------------------------------------------------------------------------
module ekx_front #(
    parameter int SAMPLE_BITS = 16,
    parameter int INDEX_BITS  = 24
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [SAMPLE_BITS-1:0]           in_sample,
    input  logic                                    in_final,
    output logic                                    push,
    output logic [INDEX_BITS+SAMPLE_BITS:0]         push_data,
    input  logic                                    queue_full
);

    localparam int OP_W = INDEX_BITS + SAMPLE_BITS + 1;

    logic signed [SAMPLE_BITS-1:0] older_reg;
    logic signed [SAMPLE_BITS-1:0] older_next;
    logic signed [SAMPLE_BITS-1:0] middle_reg;
    logic signed [SAMPLE_BITS-1:0] middle_next;
    logic [INDEX_BITS-1:0]         index_reg;
    logic [INDEX_BITS-1:0]         index_next;
    logic                          hold_valid_reg;
    logic                          hold_valid_next;
    logic [OP_W-1:0]               hold_op_reg;
    logic [OP_W-1:0]               hold_op_next;
    logic                          accept;
    logic                          is_first;
    logic                          is_interior;
    logic                          extremum;
    logic                          flat;
    logic                          op_a_valid;
    logic [OP_W-1:0]               op_a;
    logic [OP_W-1:0]               op_b;

    assign in_ready = !hold_valid_reg && !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        is_first    = (index_reg == '0);
        is_interior = (index_reg[INDEX_BITS-1:1] != '0);
        extremum    = ((middle_reg >= older_reg) && (middle_reg >= in_sample)) ||
                      ((middle_reg <= older_reg) && (middle_reg <= in_sample));
        flat        = (middle_reg == older_reg) && (middle_reg == in_sample);
        op_a_valid  = is_first || (is_interior && extremum && !flat);
        if (is_first)
        begin
            op_a = {1'b0, in_sample, {INDEX_BITS{1'b0}}};
        end
        else
        begin
            op_a = {1'b0, middle_reg, index_reg - INDEX_BITS'(1)};
        end
        op_b = {1'b1, in_sample, index_reg};
    end

    always_comb
    begin
        push            = 1'b0;
        push_data       = hold_op_reg;
        hold_valid_next = hold_valid_reg;
        hold_op_next    = hold_op_reg;
        older_next      = older_reg;
        middle_next     = middle_reg;
        index_next      = index_reg;
        if (hold_valid_reg)
        begin
            if (!queue_full)
            begin
                push            = 1'b1;
                hold_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (op_a_valid)
            begin
                push            = 1'b1;
                push_data       = op_a;
                hold_valid_next = in_final;
                hold_op_next    = op_b;
            end
            else if (in_final)
            begin
                push      = 1'b1;
                push_data = op_b;
            end
            if (in_final)
            begin
                older_next  = '0;
                middle_next = '0;
                index_next  = '0;
            end
            else
            begin
                older_next  = middle_reg;
                middle_next = in_sample;
                if (index_reg != '1)
                begin
                    index_next = index_reg + INDEX_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg      <= '0;
            middle_reg     <= '0;
            index_reg      <= '0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            older_reg      <= older_next;
            middle_reg     <= middle_next;
            index_reg      <= index_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_op_reg <= hold_op_next;
    end

endmodule

[rtl/core/ekx_back.sv]
// ----------------------------------------------------------------------------
// ekx_back
// position mapping by serial division, pending slot merge and result output
// ----------------------------------------------------------------------------
module ekx_back #(
    parameter int SAMPLE_BITS = 16,
    parameter int INDEX_BITS  = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [ekx_pkg::SCALE_BITS-1:0]        time_scale,
    input  logic [ekx_pkg::RATE_BITS-1:0]         sample_rate,
    input  logic                                  queue_empty,
    input  logic [INDEX_BITS+SAMPLE_BITS:0]       pop_data,
    output logic                                  pop,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [ekx_pkg::POS_BITS-1:0]          out_position,
    output logic signed [SAMPLE_BITS-1:0]         out_value,
    output logic                                  out_last
);

    localparam int POS_W  = ekx_pkg::POS_BITS;
    localparam int DEN_W  = ekx_pkg::DEN_BITS;
    localparam int PROD_W = ekx_pkg::SCALE_BITS + INDEX_BITS;
    localparam int NUM_W  = PROD_W + 2;
    localparam int HI_W   = NUM_W - POS_W;
    localparam int CMP_W  = (HI_W > DEN_W) ? HI_W : DEN_W;
    localparam int CNT_W  = $clog2(POS_W);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_ADD   = 3'd2;
    localparam logic [2:0] ST_CHK   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_UPD   = 3'd5;
    localparam logic [2:0] ST_FLUSH = 3'd6;

    logic [2:0]                    state_reg;
    logic [2:0]                    state_next;
    logic [INDEX_BITS-1:0]         idx_reg;
    logic [INDEX_BITS-1:0]         idx_next;
    logic signed [SAMPLE_BITS-1:0] val_reg;
    logic signed [SAMPLE_BITS-1:0] val_next;
    logic                          flush_reg;
    logic                          flush_next;
    logic [PROD_W-1:0]             prod_reg;
    logic [PROD_W-1:0]             prod_next;
    logic [NUM_W-1:0]              num_reg;
    logic [NUM_W-1:0]              num_next;
    logic [DEN_W-1:0]              rem_reg;
    logic [DEN_W-1:0]              rem_next;
    logic [POS_W-1:0]              quo_reg;
    logic [POS_W-1:0]              quo_next;
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              cnt_next;
    logic                          pend_valid_reg;
    logic                          pend_valid_next;
    logic [POS_W-1:0]              pend_pos_reg;
    logic [POS_W-1:0]              pend_pos_next;
    logic signed [SAMPLE_BITS-1:0] pend_val_reg;
    logic signed [SAMPLE_BITS-1:0] pend_val_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [POS_W-1:0]              out_pos_reg;
    logic [POS_W-1:0]              out_pos_next;
    logic signed [SAMPLE_BITS-1:0] out_val_reg;
    logic signed [SAMPLE_BITS-1:0] out_val_next;
    logic                          out_last_reg;
    logic                          out_last_next;
    logic                          out_free;
    logic [DEN_W-1:0]              den;
    logic [DEN_W:0]                trial;
    logic [DEN_W:0]                diff;
    logic                          emit_need;

    assign out_valid    = out_valid_reg;
    assign out_position = out_pos_reg;
    assign out_value    = out_val_reg;
    assign out_last     = out_last_reg;
    assign out_free     = !out_valid_reg || out_ready;
    assign den          = {sample_rate, 1'b0};
    assign trial        = {rem_reg, num_reg[POS_W-1]};
    assign diff         = trial - {1'b0, den};
    assign emit_need    = pend_valid_reg && (quo_reg > pend_pos_reg);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        val_next        = val_reg;
        flush_next      = flush_reg;
        prod_next       = prod_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_pos_next   = pend_pos_reg;
        pend_val_next   = pend_val_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_pos_next    = out_pos_reg;
        out_val_next    = out_val_reg;
        out_last_next   = out_last_reg;
        pop             = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop        = 1'b1;
                    idx_next   = pop_data[INDEX_BITS-1:0];
                    val_next   = pop_data[INDEX_BITS +: SAMPLE_BITS];
                    flush_next = pop_data[INDEX_BITS+SAMPLE_BITS];
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(time_scale) * PROD_W'(idx_reg);
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                num_next   = NUM_W'({prod_reg, 1'b0}) + NUM_W'(sample_rate);
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                // quotient would not fit, or zero rate
                if (CMP_W'(num_reg[NUM_W-1:POS_W]) >= CMP_W'(den))
                begin
                    quo_next   = '1;
                    state_next = ST_UPD;
                end
                else
                begin
                    rem_next   = DEN_W'(num_reg[NUM_W-1:POS_W]);
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                num_next = num_reg << 1;
                if (!diff[DEN_W])
                begin
                    rem_next = diff[DEN_W-1:0];
                    quo_next = {quo_reg[POS_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[DEN_W-1:0];
                    quo_next = {quo_reg[POS_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(POS_W - 1))
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (!emit_need || out_free)
                begin
                    if (!pend_valid_reg)
                    begin
                        pend_valid_next = 1'b1;
                        pend_pos_next   = quo_reg;
                        pend_val_next   = val_reg;
                    end
                    else if (emit_need)
                    begin
                        out_valid_next = 1'b1;
                        out_pos_next   = pend_pos_reg;
                        out_val_next   = pend_val_reg;
                        out_last_next  = 1'b0;
                        pend_pos_next  = quo_reg;
                        pend_val_next  = val_reg;
                    end
                    else if (quo_reg == pend_pos_reg)
                    begin
                        pend_val_next = val_reg;
                    end
                    state_next = flush_reg ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_pos_next    = pend_pos_reg;
                    out_val_next    = pend_val_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    pend_pos_next   = '0;
                    pend_val_next   = '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        val_reg      <= val_next;
        flush_reg    <= flush_next;
        prod_reg     <= prod_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        pend_pos_reg <= pend_pos_next;
        pend_val_reg <= pend_val_next;
        out_pos_reg  <= out_pos_next;
        out_val_reg  <= out_val_next;
        out_last_reg <= out_last_next;
    end

endmodule

[rtl/core/extrema_keyframe_extractor_core.sv]
// ----------------------------------------------------------------------------
// extrema_keyframe_extractor_core
// local extrema keyframe extraction with tick position mapping
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one signed sample per transfer, tlast on the last sample
//   of a signal. m_axis carries keyframes: position and value in tdata,
//   tlast on the final keyframe of the signal.
//   cfg_we/cfg_addr/cfg_wdata write time_scale (0) and sample_rate (1);
//   write only while no sample is in flight.
// timing
//   the front takes a sample per cycle while the 4-entry candidate queue has
//   room; a final sample with two candidates holds s_axis until both are queued.
//   the back works on one candidate at a time (pop, multiply, add, range
//   check, 24-step restoring divider, merge), skips the divider when the
//   position saturates and adds a flush for a final one; it pops the next
//   candidate only once the last is merged (and, if final, flushed). samples
//   without a candidate cost the back nothing.
// reset and stalls
//   reset clears the sample window, index, pending keyframe and queue and
//   loads time_scale 1000 and sample_rate 8000. a stalled m_axis holds its
//   keyframe; the back waits, the queue fills, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module extrema_keyframe_extractor_core #(
    parameter int SAMPLE_BITS = 16,
    parameter int INDEX_BITS  = 24
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]         s_axis_tdata,
    input  logic                                     s_axis_tlast,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // key_position, key_value
    output logic [((ekx_pkg::POS_BITS+SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic                                     m_axis_tlast,
    input  logic                                     cfg_we,
    input  logic [ekx_pkg::CFG_ADDR_BITS-1:0]        cfg_addr,
    input  logic [ekx_pkg::CFG_DATA_BITS-1:0]        cfg_wdata
);

    localparam int OP_W     = INDEX_BITS + SAMPLE_BITS + 1;
    localparam int OUT_BITS = ekx_pkg::POS_BITS + SAMPLE_BITS;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    logic [ekx_pkg::SCALE_BITS-1:0] time_scale_reg;
    logic [ekx_pkg::RATE_BITS-1:0]  sample_rate_reg;
    logic                           push;
    logic [OP_W-1:0]                push_data;
    logic                           queue_full;
    logic                           queue_empty;
    logic                           pop;
    logic [OP_W-1:0]                pop_data;
    logic [ekx_pkg::POS_BITS-1:0]   key_position;
    logic signed [SAMPLE_BITS-1:0]  key_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_scale_reg  <= ekx_pkg::TIME_SCALE_RESET;
            sample_rate_reg <= ekx_pkg::SAMPLE_RATE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                ekx_pkg::REG_TIME_SCALE:
                begin
                    time_scale_reg <= cfg_wdata[ekx_pkg::SCALE_BITS-1:0];
                end
                ekx_pkg::REG_SAMPLE_RATE:
                begin
                    sample_rate_reg <= cfg_wdata;
                end
                default:
                begin
                    sample_rate_reg <= sample_rate_reg;
                end
            endcase
        end
    end

    ekx_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_sample  (s_axis_tdata[SAMPLE_BITS-1:0]),
        .in_final   (s_axis_tlast),
        .push       (push),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    ekx_queue #(
        .WIDTH (OP_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    ekx_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .time_scale   (time_scale_reg),
        .sample_rate  (sample_rate_reg),
        .queue_empty  (queue_empty),
        .pop_data     (pop_data),
        .pop          (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_position (key_position),
        .out_value    (key_value),
        .out_last     (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_W'({key_value, key_position});

endmodule

[rtl/core/ekx_checker.sv]
// ----------------------------------------------------------------------------
// ekx_checker
// port level checks for the extrema keyframe extractor
// ----------------------------------------------------------------------------
module ekx_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_axis_tvalid,
    input  logic                                     s_axis_tready,
    input  logic                                     s_axis_tlast,
    input  logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    input  logic [((ekx_pkg::POS_BITS+SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
    input  logic                                     m_axis_tlast
);

    logic [3:0] owed_reg;
    logic [3:0] owed_next;
    logic       in_last_xfer;
    logic       out_last_xfer;

    assign in_last_xfer  = s_axis_tvalid && s_axis_tready && s_axis_tlast;
    assign out_last_xfer = m_axis_tvalid && m_axis_tready && m_axis_tlast;

    always_comb
    begin
        owed_next = owed_reg;
        if (in_last_xfer && !out_last_xfer)
        begin
            owed_next = owed_reg + 4'd1;
        end
        else if (!in_last_xfer && out_last_xfer && (owed_reg != '0))
        begin
            owed_next = owed_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_reg <= '0;
        end
        else
        begin
            owed_reg <= owed_next;
        end
    end

    // output quiet once reset has been sampled
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("output valid during reset");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output payload changed while stalled");

    // a final keyframe only after a final sample was taken
    a_last_owed: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> owed_reg != '0)
        else $error("end of run without a final sample");

endmodule

bind extrema_keyframe_extractor_core ekx_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_ekx_checker (.*);

[test/extrema_keyframe_extractor_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extrema_keyframe_extractor_core_tb
// self-checking bench for the extrema keyframe extractor
// ----------------------------------------------------------------------------
// a short directed plan (single- and two-sample signals, peaks, valleys,
// plateaus, full-scale samples, backwards positions after a mid-signal rate
// change, zero rate) is followed by random signals under several
// time_scale / sample_rate settings, one with a long signal that drives the
// position into saturation. every keyframe transfer is compared with a
// behavioral predictor; both stream sides idle in random bursts, except in
// the last phase.
// ----------------------------------------------------------------------------
module extrema_keyframe_extractor_core_tb;

    localparam int CFG_ADDR_BITS = ekx_pkg::CFG_ADDR_BITS;
    localparam int CFG_DATA_BITS = ekx_pkg::CFG_DATA_BITS;
    localparam int POS_BITS      = ekx_pkg::POS_BITS;
    localparam int SCALE_BITS    = ekx_pkg::SCALE_BITS;
    localparam int RATE_BITS     = ekx_pkg::RATE_BITS;

    localparam int SAMPLE_W      = 16;
    localparam int SETTLE_CYCLES = 400;
    localparam int CYCLE_LIMIT   = 600000;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        logic [CFG_ADDR_BITS-1:0] addr;
        logic [31:0]              value;
        logic                     last;
        logic                     typed;
        logic [POS_BITS-1:0]      t_pos;
        logic [SAMPLE_W-1:0]      t_val;
    } plan_row_t;

    typedef struct packed {
        logic [POS_BITS-1:0]        pos;
        logic signed [SAMPLE_W-1:0] val;
        logic                       end_flag;
    } keyframe_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    // sample
    logic [SAMPLE_W-1:0]                 s_axis_tdata = '0;
    logic                                s_axis_tlast = 1'b0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b1;
    // key_position, key_value
    logic [POS_BITS+SAMPLE_W-1:0]        m_axis_tdata;
    logic                                m_axis_tlast;
    logic                                cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0]            cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0]            cfg_wdata = '0;

    // predictor state
    logic [SCALE_BITS-1:0]      scale_reg = ekx_pkg::TIME_SCALE_RESET;
    logic [RATE_BITS-1:0]       rate_reg = ekx_pkg::SAMPLE_RATE_RESET;
    logic signed [SAMPLE_W-1:0] prior_sample = '0;
    logic signed [SAMPLE_W-1:0] mid_sample = '0;
    logic [23:0]                sample_count = '0;
    logic                       held_valid = 1'b0;
    logic [POS_BITS-1:0]        held_pos = '0;
    logic signed [SAMPLE_W-1:0] held_val = '0;

    keyframe_t expected_keys[$];
    keyframe_t want;
    plan_row_t plan[$];

    int  fail_count = 0;
    int  cycle_count = 0;
    int  stall_left = 0;
    logic calm = 1'b0;

    extrema_keyframe_extractor_core #(
        .SAMPLE_BITS(SAMPLE_W),
        .INDEX_BITS (24)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void add_row(input plan_row_t row);
        plan.insert(plan.size(), row);
    endfunction

    function automatic void queue_key(input keyframe_t key);
        expected_keys.insert(expected_keys.size(), key);
    endfunction

    function automatic logic [POS_BITS-1:0] tick_position(input logic [23:0] idx);
        logic [63:0] num;
        logic [63:0] quot;
        if (rate_reg == 0)
            return '1;
        num = 64'(scale_reg) * 64'(idx) * 2 + 64'(rate_reg);
        quot = num / (64'(rate_reg) * 2);
        return (quot > 64'hFF_FFFF) ? '1 : quot[POS_BITS-1:0];
    endfunction

    function automatic void offer_candidate(input logic [23:0] idx,
                                            input logic signed [SAMPLE_W-1:0] val);
        logic [POS_BITS-1:0] pos;
        pos = tick_position(idx);
        if (!held_valid)
        begin
            held_valid = 1'b1;
            held_pos = pos;
            held_val = val;
        end
        else if (pos > held_pos)
        begin
            queue_key('{held_pos, held_val, 1'b0});
            held_pos = pos;
            held_val = val;
        end
        else if (pos == held_pos)
        begin
            held_val = val;
        end
    endfunction

    function automatic void predict_keyframes(input logic signed [SAMPLE_W-1:0] s,
                                              input logic fin);
        logic [23:0] idx;
        logic        extreme;
        logic        flat;
        idx = sample_count;
        if (idx == 0)
        begin
            offer_candidate(24'd0, s);
        end
        else if (idx >= 2)
        begin
            extreme = (mid_sample >= prior_sample && mid_sample >= s) ||
                      (mid_sample <= prior_sample && mid_sample <= s);
            flat = (mid_sample == prior_sample) && (mid_sample == s);
            if (extreme && !flat)
                offer_candidate(idx - 24'd1, mid_sample);
        end
        if (fin)
        begin
            offer_candidate(idx, s);
            queue_key('{held_pos, held_val, 1'b1});
            prior_sample = '0;
            mid_sample = '0;
            sample_count = '0;
            held_valid = 1'b0;
            held_pos = '0;
            held_val = '0;
        end
        else
        begin
            prior_sample = mid_sample;
            mid_sample = s;
            if (idx != 24'hFF_FFFF)
                sample_count = idx + 24'd1;
        end
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic fin,
                               input logic typed, input logic [POS_BITS-1:0] t_pos,
                               input logic [SAMPLE_W-1:0] t_val);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= value;
        s_axis_tlast <= fin;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_keyframes(value, fin);
        if (typed)
            expected_keys[expected_keys.size()-1] = '{t_pos, t_val, fin};
    endtask

    task automatic drain_keyframes();
        s_axis_tvalid <= 1'b0;
        while (expected_keys.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
                             input logic [CFG_DATA_BITS-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (addr == ekx_pkg::REG_TIME_SCALE)
            scale_reg = value[SCALE_BITS-1:0];
        else
            rate_reg = value[RATE_BITS-1:0];
    endtask

    task automatic send_signal(input int len, input int style);
        logic [SAMPLE_W-1:0] v;
        v = 16'($urandom_range(0, 65535));
        for (int i = 0; i < len; i++)
        begin
            case (style)
                0: v = 16'($urandom_range(0, 65535));
                1: v = 16'($urandom_range(0, 4)) - 16'd2;
                2:
                begin
                    case ($urandom_range(0, 3))
                        0: v = 16'h8000;
                        1: v = 16'h7FFF;
                        2: v = 16'h0000;
                        default: v = 16'hFFFF;
                    endcase
                end
                default: v = v + 16'($urandom_range(0, 200)) - 16'd100;
            endcase
            send_sample(v, i == len - 1, 1'b0, '0, '0);
        end
    endtask

    // result side stalls
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            if (stall_left == 1)
                m_axis_tready <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= $urandom_range(1, 10);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_keys.size() == 0)
            begin
                $error("unexpected keyframe: key_position %0d key_value %0d",
                       m_axis_tdata[POS_BITS-1:0],
                       $signed(m_axis_tdata[POS_BITS+SAMPLE_W-1:POS_BITS]));
                fail_count++;
            end
            else
            begin
                want = expected_keys.pop_front();
                if (m_axis_tdata[POS_BITS-1:0] !== want.pos)
                begin
                    $error("key_position mismatch: expected %0d, actual %0d",
                           want.pos, m_axis_tdata[POS_BITS-1:0]);
                    fail_count++;
                end
                if (m_axis_tdata[POS_BITS+SAMPLE_W-1:POS_BITS] !== want.val)
                begin
                    $error("key_value mismatch: expected %0d, actual %0d", want.val,
                           $signed(m_axis_tdata[POS_BITS+SAMPLE_W-1:POS_BITS]));
                    fail_count++;
                end
                if (m_axis_tlast !== want.end_flag)
                begin
                    $error("end_of_run mismatch: expected %0d, actual %0d",
                           want.end_flag, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        // reset settings, full-scale single-sample signals
        add_row('{ROW_SAMPLE, ekx_pkg::REG_TIME_SCALE, 32767, 1'b1, 1'b1, 24'd0, 16'h7FFF});
        add_row('{ROW_SAMPLE, ekx_pkg::REG_TIME_SCALE, -32768, 1'b1, 1'b1, 24'd0, 16'h8000});
        // two-sample signal
        add_row('{ROW_SAMPLE, ekx_pkg::REG_TIME_SCALE, 5, 1'b0, 1'b0, 24'd0, 16'd0});
        add_row('{ROW_SAMPLE, ekx_pkg::REG_TIME_SCALE, -5, 1'b1, 1'b0, 24'd0, 16'd0});
        // one tick per sample: peaks, valleys, plateaus, flat run
        add_row('{ROW_WRITE, ekx_pkg::REG_TIME_SCALE, 1, 1'b0, 1'b0, 24'd0, 16'd0});
        add_row('{ROW_WRITE, ekx_pkg::REG_SAMPLE_RATE, 1, 1'b0, 1'b0, 24'd0, 16'd0});
        add_row('{ROW_SAMPLE, ekx_pkg::REG_TIME_SCALE, 0, 1'b0, 1'b0, 24'd0, 16'd0});
        add_row('{ROW_SAMPLE, ekx_pkg::REG_TIME_SCALE, 100, 1'b0, 1'b0, 24'd0, 16'd0});
        add_row('{ROW_SAMPLE, ekx_pkg::REG_TIME_SCALE, -100, 1'b0, 1'b0, 24'd0, 16'd0});
        add_row('{ROW_SAMPLE, ekx_pkg::REG_TIME_SCALE, -100, 1'b0, 1'b0, 24'd0, 16'd0});
        add_row('{ROW_SAMPLE, ekx_pkg::REG_TIME_SCALE, -100, 1'b0, 1'b0, 24'd0, 16'd0});
        add_row('{ROW_SAMPLE, ekx_pkg::REG_TIME_SCALE, 50, 1'b0, 1'b0, 24'd0, 16'd0});
        add_row('{ROW_SAMPLE, ekx_pkg::REG_TIME_SCALE, 50, 1'b0, 1'b0, 24'd0, 16'd0});
        add_row('{ROW_SAMPLE, ekx_pkg::REG_TIME_SCALE, 50, 1'b0, 1'b0, 24'd0, 16'd0});
        add_row('{ROW_SAMPLE, ekx_pkg::REG_TIME_SCALE, 32767, 1'b0, 1'b0, 24'd0, 16'd0});
        add_row('{ROW_SAMPLE, ekx_pkg::REG_TIME_SCALE, -32768, 1'b1, 1'b0, 24'd0, 16'd0});
        // rate raised mid-signal, later candidates map backwards
        add_row('{ROW_SAMPLE, ekx_pkg::REG_TIME_SCALE, 1, 1'b0, 1'b0, 24'd0, 16'd0});
        add_row('{ROW_SAMPLE, ekx_pkg::REG_TIME_SCALE, 9, 1'b0, 1'b0, 24'd0, 16'd0});
        add_row('{ROW_SAMPLE, ekx_pkg::REG_TIME_SCALE, 2, 1'b0, 1'b0, 24'd0, 16'd0});
        add_row('{ROW_WRITE, ekx_pkg::REG_SAMPLE_RATE, 192000, 1'b0, 1'b0, 24'd0, 16'd0});
        add_row('{ROW_SAMPLE, ekx_pkg::REG_TIME_SCALE, 3, 1'b0, 1'b0, 24'd0, 16'd0});
        add_row('{ROW_SAMPLE, ekx_pkg::REG_TIME_SCALE, 1, 1'b1, 1'b0, 24'd0, 16'd0});
        // zero rate maps everything to the top position
        add_row('{ROW_WRITE, ekx_pkg::REG_SAMPLE_RATE, 0, 1'b0, 1'b0, 24'd0, 16'd0});
        add_row('{ROW_SAMPLE, ekx_pkg::REG_TIME_SCALE, 4, 1'b1, 1'b1, 24'hFF_FFFF, 16'd4});
        add_row('{ROW_SAMPLE, ekx_pkg::REG_TIME_SCALE, 4, 1'b0, 1'b0, 24'd0, 16'd0});
        add_row('{ROW_SAMPLE, ekx_pkg::REG_TIME_SCALE, -4, 1'b0, 1'b0, 24'd0, 16'd0});
        add_row('{ROW_SAMPLE, ekx_pkg::REG_TIME_SCALE, 4, 1'b1, 1'b0, 24'd0, 16'd0});

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                drain_keyframes();
                write_reg(plan[i].addr, plan[i].value[CFG_DATA_BITS-1:0]);
            end
            else
            begin
                send_sample(plan[i].value[SAMPLE_W-1:0], plan[i].last, plan[i].typed,
                            plan[i].t_pos, plan[i].t_val);
            end
        end

        for (int phase = 0; phase < 6; phase++)
        begin
            int sent;
            int len;
            logic [SCALE_BITS-1:0] ts;
            logic [RATE_BITS-1:0]  sr;
            case (phase)
                0:
                begin
                    ts = 16'd65535;
                    sr = 18'd1;
                end
                1:
                begin
                    ts = ekx_pkg::TIME_SCALE_RESET;
                    sr = ekx_pkg::SAMPLE_RATE_RESET;
                end
                2:
                begin
                    ts = 16'd1;
                    sr = 18'd192000;
                end
                3:
                begin
                    ts = 16'($urandom_range(1, 65535));
                    sr = 18'($urandom_range(1, 192000));
                end
                4:
                begin
                    ts = 16'd65535;
                    sr = 18'd192000;
                end
                default:
                begin
                    ts = 16'($urandom_range(100, 4000));
                    sr = 18'($urandom_range(1, 400));
                end
            endcase
            drain_keyframes();
            write_reg(ekx_pkg::REG_TIME_SCALE, CFG_DATA_BITS'(ts));
            write_reg(ekx_pkg::REG_SAMPLE_RATE, sr);
            if (phase == 5)
                calm = 1'b1;
            // long signal, positions run into saturation
            if (phase == 0)
                send_signal(260, 3);
            sent = 0;
            while (sent < 8)
            begin
                if ($urandom_range(0, 5) == 0)
                    len = $urandom_range(1, 2);
                else
                    len = $urandom_range(3, 14);
                send_signal(len, $urandom_range(0, 3));
                sent += len;
            end
        end

        drain_keyframes();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
